// ===== design/nfa_pkg.sv =====
// shared constants and control/status types for the next-fit number allocator
package nfa_pkg;

  // fixed field widths
  localparam int NUM_W    = 10;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // bitmap word geometry
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED  = 2'd2;

  // reset value of the count register
  localparam logic [NUM_W-1:0] COUNT_RESET = 10'd1023;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clear;
    logic step;
    logic commit;
  } dp_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic done;
    logic clr_last;
  } dp_stat_t;

endpackage

// ===== design/next_fit_number_allocator.sv =====
// Next-fit identifier allocator: top level joining controller and datapath.
// An item is accepted only in the idle state, so one item is in flight at a time;
// allocate scans bitmap words from the next-fit start until a free bit or the scan end.
// Reset clears control state, sets count to 1023, then a clearing pass that zeroes
// every bitmap word runs before the first item is accepted.
module next_fit_number_allocator
  import nfa_pkg::*;
#(
  parameter int MAX_NUMBERS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [NUM_W-1:0]    number_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [NUM_W-1:0]    granted_number_o,
  output logic                is_used_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [NUM_W-1:0]    cfg_count_in_use_i
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // count register is always writable
  assign cfg_ready_o = 1'b1;

  // controller
  nfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // datapath
  nfa_datapath #(
    .MAX_NUMBERS (MAX_NUMBERS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .cmd_i            (cmd_i),
    .number_i         (number_i),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (cfg_count_in_use_i),
    .status_o         (status_o),
    .granted_number_o (granted_number_o),
    .is_used_o        (is_used_o)
  );

endmodule

// ===== design/nfa_datapath.sv =====
// bitmap memory, next-fit word scan, count register and result registers
module nfa_datapath
  import nfa_pkg::*;
#(
  parameter int MAX_NUMBERS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_ctrl_t            ctrl_i,
  output dp_stat_t            stat_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [NUM_W-1:0]    number_i,
  input  logic                cfg_we_i,
  input  logic [NUM_W-1:0]    cfg_data_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [NUM_W-1:0]    granted_number_o,
  output logic                is_used_o
);

  // only numbers reachable through a NUM_W-bit field need storage
  localparam int STORE  = (MAX_NUMBERS < (2 ** NUM_W)) ? MAX_NUMBERS : (2 ** NUM_W);
  localparam int ROWS   = (STORE + WORD_W - 1) / WORD_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAP_I  = ((MAX_NUMBERS - 1) < ((2 ** NUM_W) - 1)) ?
                          (MAX_NUMBERS - 1) : ((2 ** NUM_W) - 1);
  localparam logic [NUM_W-1:0]  CAP      = NUM_W'(CAP_I);
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

  logic [WORD_W-1:0] mem [ROWS];

  logic [NUM_W-1:0]    cnt_q, last_q, p_q, num_q;
  logic [CMD_W-1:0]    op_q;
  logic                phase_q;
  logic [ROW_AW-1:0]   row_q, row_d, clr_q;
  logic [WORD_W-1:0]   rdata_q;
  logic [STATUS_W-1:0] status_q;
  logic [NUM_W-1:0]    granted_q;
  logic                used_q;

  logic [NUM_W-1:0]  eff, p_calc, lo, hi, alloc_num;
  logic [ROW_AW-1:0] lo_row, hi_row, start_row;
  logic [WORD_W-1:0] mask_lo, mask_hi, free, sel_bit, wdata;
  logic [BIT_W-1:0]  enc;
  logic              found, row_last, alloc_done, in_rng, mark, we;
  logic [ROW_AW-1:0] waddr;

  // effective count and next-fit start point
  assign eff    = (cnt_q > CAP) ? CAP : cnt_q;
  assign p_calc = (last_q == '0 || last_q >= eff) ? NUM_W'(1) : last_q + NUM_W'(1);

  // scan bounds: first pass from start to count, second pass from 1 to start-1
  assign lo     = phase_q ? NUM_W'(1) : p_q;
  assign hi     = phase_q ? (p_q - NUM_W'(1)) : eff;
  assign lo_row = lo[BIT_W +: ROW_AW];
  assign hi_row = hi[BIT_W +: ROW_AW];

  assign mask_lo = (row_q == lo_row) ? ({WORD_W{1'b1}} << lo[BIT_W-1:0]) : {WORD_W{1'b1}};
  assign mask_hi = (row_q == hi_row) ?
                   ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi[BIT_W-1:0])) :
                   {WORD_W{1'b1}};
  assign free    = ~rdata_q & mask_lo & mask_hi;
  assign found   = |free;

  // lowest free bit in the current word
  always_comb begin
    enc = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free[j]) begin
        enc = BIT_W'(j);
      end
    end
  end

  assign alloc_num  = NUM_W'({row_q, enc});
  assign row_last   = (row_q == hi_row);
  assign alloc_done = found || (row_last && (phase_q || p_q == NUM_W'(1)));

  // release and query look at the addressed mark
  assign in_rng = (num_q != '0) && (num_q <= eff);
  assign mark   = rdata_q[num_q[BIT_W-1:0]];

  assign stat_o.done     = (op_q == CMD_ALLOC) ? alloc_done : 1'b1;
  assign stat_o.clr_last = (clr_q == ROW_LAST);

  // read row selection
  assign start_row = (cmd_i == CMD_ALLOC) ? p_calc[BIT_W +: ROW_AW] : number_i[BIT_W +: ROW_AW];

  always_comb begin
    row_d = row_q;
    if (ctrl_i.accept) begin
      row_d = start_row;
    end else if (ctrl_i.step) begin
      row_d = row_last ? '0 : row_q + ROW_AW'(1);
    end
  end

  // write port: clearing pass or commit of a changed word
  always_comb begin
    sel_bit = '0;
    wdata   = rdata_q;
    we      = 1'b0;
    waddr   = row_q;
    if (ctrl_i.clear) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (ctrl_i.commit) begin
      case (op_q)
        CMD_ALLOC: begin
          sel_bit = WORD_W'(1) << enc;
          wdata   = rdata_q | sel_bit;
          we      = found;
        end
        CMD_RELEASE: begin
          sel_bit = WORD_W'(1) << num_q[BIT_W-1:0];
          wdata   = rdata_q & ~sel_bit;
          we      = in_rng && mark;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[row_d];
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= COUNT_RESET;
      last_q  <= '0;
      clr_q   <= '0;
      row_q   <= '0;
      phase_q <= 1'b0;
      op_q    <= CMD_QUERY;
    end else begin
      row_q <= row_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_data_i;
      end
      if (ctrl_i.clear) begin
        clr_q <= clr_q + ROW_AW'(1);
      end
      if (ctrl_i.accept) begin
        op_q    <= cmd_i;
        phase_q <= 1'b0;
      end else if (ctrl_i.step && row_last) begin
        phase_q <= 1'b1;
      end
      if (ctrl_i.commit && op_q == CMD_ALLOC && found) begin
        last_q <= alloc_num;
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      num_q <= number_i;
      p_q   <= p_calc;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      status_q  <= ST_OK;
      granted_q <= '0;
      used_q    <= 1'b0;
      case (op_q)
        CMD_ALLOC: begin
          status_q  <= found ? ST_OK : ST_EXHAUSTED;
          granted_q <= found ? alloc_num : '0;
        end
        CMD_RELEASE: begin
          status_q <= (in_rng && mark) ? ST_OK : ST_NOT_USED;
        end
        CMD_QUERY: begin
          used_q <= in_rng && mark;
        end
        default: begin
          status_q <= ST_OK;
        end
      endcase
    end
  end

  assign status_o         = status_q;
  assign granted_number_o = granted_q;
  assign is_used_o        = used_q;

  // a granted number always lies in 1..count
  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.commit && op_q == CMD_ALLOC && found) |-> (alloc_num != '0 && alloc_num <= eff))
    else $error("granted number out of range");

  // the second pass never falls back to the first
  a_phase_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q && ctrl_i.step) |=> phase_q)
    else $error("scan pass went backward");

  // a nonzero granted number only comes with an ok status
  a_grant_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |=> (granted_q == '0 || status_q == ST_OK))
    else $error("granted number with failing status");

endmodule

// ===== design/nfa_ctrl.sv =====
// controller state machine: clearing pass, accept, scan, result handoff
module nfa_ctrl
  import nfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_BUSY
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // commands to the datapath
  assign in_ready_o    = (state_q == S_IDLE);
  assign ctrl_o.accept = (state_q == S_IDLE) && in_valid_i;
  assign ctrl_o.clear  = (state_q == S_CLEAR);
  assign ctrl_o.step   = (state_q == S_BUSY) && !stat_i.done;
  assign ctrl_o.commit = (state_q == S_BUSY) && stat_i.done && slot_free;

  assign out_valid_o = out_valid_q;

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (stat_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (stat_i.done && slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_CLEAR;
        end
      endcase
    end
  end

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.accept |=> (state_q == S_BUSY))
    else $error("accepted item did not start");

  // a commit always presents a result
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.commit |=> out_valid_q)
    else $error("commit without result");

  // an unfinished scan keeps the controller busy
  a_scan_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.step |=> (state_q == S_BUSY))
    else $error("scan dropped");

endmodule

// ===== tb/sv/next_fit_number_allocator_test.sv =====
// self-checking testbench for the next-fit number allocator
`timescale 1ns / 1ps

module next_fit_number_allocator_test;
  import nfa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_SIZE     = 1024;

  // one result item as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    granted;
    logic                used;
  } reply_t;

  // keeps a copy of the bitmap and predicts each reply in order
  class grant_scoreboard;
    bit               used_mark [POOL_SIZE];
    logic [NUM_W-1:0] last_grant;
    logic [NUM_W-1:0] count_limit;
    reply_t           awaited_replies[$];
    int               granted_ids[$];
    int               errors;

    function new();
      last_grant  = '0;
      count_limit = COUNT_RESET;
      errors      = 0;
    endfunction

    function void set_count(logic [NUM_W-1:0] value);
      count_limit = value;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    function bit in_range(int n);
      return n >= 1 && n <= count_limit;
    endfunction

    // free numbers left in 1..count
    function int free_left();
      int n;
      n = 0;
      for (int i = 1; i <= count_limit; i++) begin
        if (!used_mark[i]) n++;
      end
      return n;
    endfunction

    // pick a previously granted number to hand back, or a random one in 1..count if none
    function logic [NUM_W-1:0] take_used();
      int idx;
      int v;
      if (granted_ids.size() == 0) return NUM_W'($urandom_range(1, count_limit));
      idx = $urandom_range(granted_ids.size() - 1);
      v = granted_ids[idx];
      granted_ids.delete(idx);
      return v[NUM_W-1:0];
    endfunction

    // work out the reply to an accepted request
    function void note_request(logic [CMD_W-1:0] cmd, logic [NUM_W-1:0] num);
      reply_t r;
      int     p;
      bit     found;
      r = '0;
      found = 1'b0;
      case (cmd)
        CMD_ALLOC: begin
          r.status = ST_EXHAUSTED;
          // next-fit scan, restart at 1 when the last grant is stale
          p = (last_grant == 0 || last_grant >= count_limit) ? 1 : int'(last_grant) + 1;
          for (int i = 0; i < count_limit; i++) begin
            if (!found && !used_mark[p]) begin
              found = 1'b1;
              used_mark[p] = 1'b1;
              last_grant = p[NUM_W-1:0];
              r.status = ST_OK;
              r.granted = p[NUM_W-1:0];
              granted_ids.push_back(p);
            end
            p = (p >= count_limit) ? 1 : p + 1;
          end
        end
        CMD_RELEASE: begin
          if (in_range(int'(num)) && used_mark[num]) used_mark[num] = 1'b0;
          else r.status = ST_NOT_USED;
        end
        CMD_QUERY: begin
          r.used = in_range(int'(num)) && used_mark[num];
        end
        default: begin
        end
      endcase
      awaited_replies.push_back(r);
    endfunction

    // compare a reply with the oldest prediction
    function void check_reply(logic [STATUS_W-1:0] status, logic [NUM_W-1:0] granted,
                              logic used);
      reply_t e;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d granted=%0d is_used=%0b",
                 $time, status, granted, used);
        errors++;
        return;
      end
      e = awaited_replies.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, status);
        errors++;
      end
      if (granted !== e.granted) begin
        $display("%0t: granted_number expected %0d got %0d", $time, e.granted, granted);
        errors++;
      end
      if (used !== e.used) begin
        $display("%0t: is_used expected %0b got %0b", $time, e.used, used);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                in_valid_i         = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i              = CMD_ALLOC;
  logic [NUM_W-1:0]    number_i           = '0;
  logic                out_valid_o;
  logic                out_ready_i        = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [NUM_W-1:0]    granted_number_o;
  logic                is_used_o;
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [NUM_W-1:0]    cfg_count_in_use_i = '0;

  grant_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  next_fit_number_allocator i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .number_i           (number_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .granted_number_o   (granted_number_o),
    .is_used_o          (is_used_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_count_in_use_i (cfg_count_in_use_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // reset asserted at the start, then released
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // random back-pressure on the reply side
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // reply checking and watchdog on idle cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_reply(status_o, granted_number_o, is_used_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("next_fit_number_allocator_test NOT OK");
        $finish;
      end
    end
  end

  // send one request item, with random idle cycles ahead of it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NUM_W-1:0] num);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    number_i   <= num;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, num);
  endtask

  // write the count register
  task automatic write_count(input logic [NUM_W-1:0] value);
    cfg_valid_i        <= 1'b1;
    cfg_count_in_use_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_count(value);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every reply is back and the block has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed traffic: allocate, hand back granted numbers, query
  task automatic send_random(input int alloc_pct);
    int               r;
    logic [CMD_W-1:0] cmd;
    logic [NUM_W-1:0] num;
    r   = $urandom_range(99);
    num = NUM_W'($urandom_range(1023));
    if (r < alloc_pct) begin
      cmd = CMD_ALLOC;
    end else if (r < alloc_pct + 25) begin
      cmd = CMD_RELEASE;
      num = sb.take_used();
    end else if (r < alloc_pct + 40) begin
      cmd = CMD_QUERY;
      if (r[0]) num = NUM_W'($urandom_range(1, sb.count_limit));
    end else begin
      cmd = CMD_W'($urandom_range(3));
    end
    send_item(cmd, num);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [NUM_W-1:0] count, input int items);
    drain();
    write_count(count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (items) send_random(45);
  endtask

  // stimulus
  initial begin
    sb = new();
    // no register write until reset is released
    wait (rst_ni);
    @(posedge clk_i);

    // small pool: fill, exhaust, release twice, out-of-range numbers
    write_count(10'd3);
    repeat (4) send_item(CMD_ALLOC, '0);
    send_item(CMD_QUERY, 10'd2);
    send_item(CMD_RELEASE, 10'd2);
    send_item(CMD_RELEASE, 10'd2);
    send_item(CMD_ALLOC, 10'd1023);
    send_item(CMD_QUERY, 10'd0);
    send_item(CMD_RELEASE, 10'd0);
    send_item(CMD_QUERY, 10'd1023);
    send_item(CMD_RELEASE, 10'd1023);
    send_item(CMD_UNKNOWN, 10'd1023);

    // count below the last grant, so the scan restarts at 1
    drain();
    write_count(10'd1);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_RELEASE, 10'd1);
    send_item(CMD_ALLOC, '0);

    // zero count grants nothing, marks above it are hidden
    drain();
    write_count(10'd0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_QUERY, 10'd1);

    // raised count brings the hidden marks back
    drain();
    write_count(COUNT_RESET);
    send_item(CMD_QUERY, 10'd3);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_QUERY, 10'd1023);
    send_item(CMD_RELEASE, 10'd1023);
    send_item(CMD_ALLOC, 10'd1023);
    send_item(CMD_UNKNOWN, 10'd0);

    // random phases over several counts and idling patterns
    run_phase(0, 0, COUNT_RESET, 80);
    run_phase(88, 0, 10'd9, 80);
    run_phase(0, 88, 10'd1, 80);
    run_phase(31, 31, 10'd64, 80);
    run_phase(0, 0, 10'd0, 40);
    run_phase(31, 31, NUM_W'($urandom_range(2, 40)), 80);

    // fill the full pool up to exhaustion, then churn so the scan wraps at the top
    run_phase(0, 0, COUNT_RESET, 0);
    while (sb.free_left() != 0) begin
      if ($urandom_range(9) == 0) send_item(CMD_QUERY, NUM_W'($urandom_range(1023)));
      else send_item(CMD_ALLOC, NUM_W'($urandom_range(1023)));
    end
    repeat (3) send_item(CMD_ALLOC, '0);
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    repeat (80) send_random(45);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("next_fit_number_allocator_test OK");
    end else begin
      $display("next_fit_number_allocator_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/nfa_pkg.sv
design/nfa_datapath.sv
design/nfa_ctrl.sv
design/next_fit_number_allocator.sv
tb/sv/next_fit_number_allocator_test.sv
